// ===== rtl/v2r_pkg.sv =====
package v2r_pkg;

	localparam int FRAC_BITS = 14;
	localparam int IW = 16;

	// Dot product, rounded dot product and eta squared.
	localparam int PW = 2 * IW + 1;
	localparam int DW = PW - FRAC_BITS;
	localparam int E2W = 2 * IW + 1 - FRAC_BITS;

	// One minus d squared, before and after rounding.
	localparam int TMPW = 2 * DW + 2;
	localparam int TW = TMPW - FRAC_BITS;

	// Eta squared times t, and the radicand.
	localparam int ETW = E2W + 1 + TW;
	localparam int KW = ETW + 1;
	localparam int KRW = ((ETW + 1) / 2) * 2;

	// Square root pipeline.
	localparam int SW = KRW / 2;
	localparam int NSTEP = SW;
	localparam int NSTG = (NSTEP + 1) / 2;

	// Coefficient of the normal and the output terms.
	localparam int EDW = IW + 1 + DW;
	localparam int C0W = EDW - FRAC_BITS;
	localparam int CW = ((C0W > SW + 1) ? C0W : SW + 1) + 1;
	localparam int EIW = 2 * IW + 1;
	localparam int CNW = CW + IW;
	localparam int QW = CNW + 1;
	localparam int RW = QW + 1 - FRAC_BITS;

	localparam int HALF = 1 << (FRAC_BITS - 1);
	localparam longint ONE2 = longint'(1) << (2 * FRAC_BITS);
	localparam int SAT_MAX = 32767;
	localparam int SAT_MIN = -32768;

	typedef struct packed {
		logic signed [IW-1:0] inc_x;
		logic signed [IW-1:0] inc_y;
		logic signed [IW-1:0] norm_x;
		logic signed [IW-1:0] norm_y;
		logic [IW-1:0]        eta;
	} v2r_in_t;

	typedef struct packed {
		logic signed [IW-1:0] out_x;
		logic signed [IW-1:0] out_y;
		logic                 total_internal;
	} v2r_out_t;

	typedef struct packed {
		logic [IW-1:0]         eta;
		logic signed [IW-1:0]  inc_x;
		logic signed [IW-1:0]  inc_y;
		logic signed [IW-1:0]  norm_x;
		logic signed [IW-1:0]  norm_y;
		logic signed [C0W-1:0] c0;
		logic                  tir;
	} v2r_side_t;

	typedef struct packed {
		logic           vld;
		logic [KRW-1:0] rad;
		v2r_side_t      side;
	} v2r_mid_t;

	typedef struct packed {
		logic          vld;
		logic [SW-1:0] root;
		v2r_side_t     side;
	} v2r_root_t;

	typedef struct packed {
		logic [KRW-1:0] rem;
		logic [KRW-1:0] res;
	} v2r_sq_t;

	// One step of the bit-by-bit integer square root.
	function automatic v2r_sq_t v2r_root_step(v2r_sq_t cur, int j);
		logic [KRW-1:0] bitv;
		logic [KRW-1:0] trial;
		v2r_sq_t        nxt;
		bitv = {{(KRW-1){1'b0}}, 1'b1} << (KRW - 2 - 2 * j);
		trial = cur.res + bitv;
		if (cur.rem >= trial) begin
			nxt.rem = cur.rem - trial;
			nxt.res = (cur.res >> 1) + bitv;
		end else begin
			nxt.rem = cur.rem;
			nxt.res = cur.res >> 1;
		end
		return nxt;
	endfunction

endpackage

// ===== rtl/v2r_req_if.sv =====
interface v2r_req_if;
	import v2r_pkg::*;

	logic    valid;
	logic    ready;
	v2r_in_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/v2r_rsp_if.sv =====
interface v2r_rsp_if;
	import v2r_pkg::*;

	logic     valid;
	logic     ready;
	v2r_out_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/v2r_front.sv =====
module v2r_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_vld,
	input  v2r_pkg::v2r_in_t in_data,
	output v2r_pkg::v2r_mid_t mid
);
	import v2r_pkg::*;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;

	v2r_in_t x_s1, x_s2, x_s3, x_s4, x_s5;
	logic signed [2*IW-1:0] pxx_s1, pyy_s1;
	logic [2*IW-1:0]        ee_s1;
	logic signed [DW-1:0]   d_s2;
	logic [E2W-1:0]         e2_s2, e2_s3, e2_s4;
	logic signed [2*DW-1:0] dd_s3;
	logic signed [EDW-1:0]  ed_s3;
	logic signed [TW-1:0]   t_s4;
	logic signed [C0W-1:0]  c0_s4, c0_s5;
	logic signed [ETW-1:0]  et_s5;
	logic [KRW-1:0]         rad_s6;
	v2r_side_t              side_s6;

	logic signed [PW-1:0]   psum;
	logic signed [PW:0]     pround;
	logic [2*IW:0]          eround;
	logic signed [TMPW-1:0] tmp;
	logic signed [TMPW-1:0] tround;
	logic signed [EDW:0]    edround;
	logic signed [KW-1:0]   k;

	always_comb begin
		psum = PW'(pxx_s1) + PW'(pyy_s1);
		pround = (PW+1)'(psum) + (PW+1)'(HALF);
		eround = (2*IW+1)'(ee_s1) + (2*IW+1)'(HALF);
		tmp = TMPW'(ONE2) - TMPW'(dd_s3);
		tround = tmp + TMPW'(HALF);
		edround = (EDW+1)'(ed_s3) + (EDW+1)'(HALF);
		k = KW'(ONE2) - KW'(et_s5);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= in_data;
			pxx_s1 <= in_data.norm_x * in_data.inc_x;
			pyy_s1 <= in_data.norm_y * in_data.inc_y;
			ee_s1 <= in_data.eta * in_data.eta;

			x_s2 <= x_s1;
			d_s2 <= DW'(pround >>> FRAC_BITS);
			e2_s2 <= E2W'(eround >> FRAC_BITS);

			x_s3 <= x_s2;
			e2_s3 <= e2_s2;
			dd_s3 <= d_s2 * d_s2;
			ed_s3 <= $signed({1'b0, x_s2.eta}) * d_s2;

			x_s4 <= x_s3;
			e2_s4 <= e2_s3;
			t_s4 <= TW'(tround >>> FRAC_BITS);
			c0_s4 <= C0W'(edround >>> FRAC_BITS);

			x_s5 <= x_s4;
			c0_s5 <= c0_s4;
			et_s5 <= $signed({1'b0, e2_s4}) * t_s4;

			rad_s6 <= k[KW-1] ? '0 : k[KRW-1:0];
			side_s6.eta <= x_s5.eta;
			side_s6.inc_x <= x_s5.inc_x;
			side_s6.inc_y <= x_s5.inc_y;
			side_s6.norm_x <= x_s5.norm_x;
			side_s6.norm_y <= x_s5.norm_y;
			side_s6.c0 <= c0_s5;
			side_s6.tir <= k[KW-1];
		end
	end

	always_comb begin
		mid.vld = vld_s6;
		mid.rad = rad_s6;
		mid.side = side_s6;
	end

endmodule

// ===== rtl/v2r_sqrt.sv =====
module v2r_sqrt (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  v2r_pkg::v2r_mid_t  mid,
	output v2r_pkg::v2r_root_t root
);
	import v2r_pkg::*;

	logic      vld_s [NSTG];
	v2r_sq_t   sq_s [NSTG];
	v2r_side_t side_s [NSTG];

	for (genvar g = 0; g < NSTG; g++) begin : g_stage
		logic      prev_vld;
		v2r_sq_t   prev_sq;
		v2r_side_t prev_side;
		v2r_sq_t   step_a;
		v2r_sq_t   step_b;

		if (g == 0) begin : g_first
			assign prev_vld = mid.vld;
			assign prev_sq = '{rem: mid.rad, res: '0};
			assign prev_side = mid.side;
		end else begin : g_next
			assign prev_vld = vld_s[g-1];
			assign prev_sq = sq_s[g-1];
			assign prev_side = side_s[g-1];
		end

		always_comb begin
			step_a = v2r_root_step(prev_sq, 2 * g);
			if (2 * g + 1 < NSTEP) begin
				step_b = v2r_root_step(step_a, 2 * g + 1);
			end else begin
				step_b = step_a;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else if (en) begin
				vld_s[g] <= prev_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sq_s[g] <= step_b;
				side_s[g] <= prev_side;
			end
		end
	end

	assign root.vld = vld_s[NSTG-1];
	assign root.root = sq_s[NSTG-1].res[SW-1:0];
	assign root.side = side_s[NSTG-1];

endmodule

// ===== rtl/v2r_back.sv =====
module v2r_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  v2r_pkg::v2r_root_t root,
	output logic               out_vld,
	output v2r_pkg::v2r_out_t  out_data
);
	import v2r_pkg::*;

	logic vld_s1, vld_s2, vld_s3;

	v2r_side_t             side_s1;
	logic signed [CW-1:0]  c_s1;
	logic signed [EIW-1:0] ex_s2, ey_s2;
	logic signed [CNW-1:0] cx_s2, cy_s2;
	logic                  tir_s2;
	v2r_out_t              out_s3;

	logic signed [QW-1:0] dx, dy;
	logic signed [QW:0]   rxf, ryf;
	logic signed [RW-1:0] rx, ry;
	logic signed [IW-1:0] sx, sy;

	always_comb begin
		dx = QW'(ex_s2) - QW'(cx_s2);
		dy = QW'(ey_s2) - QW'(cy_s2);
		rxf = (QW+1)'(dx) + (QW+1)'(HALF);
		ryf = (QW+1)'(dy) + (QW+1)'(HALF);
		rx = RW'(rxf >>> FRAC_BITS);
		ry = RW'(ryf >>> FRAC_BITS);

		if (rx > RW'(SAT_MAX)) begin
			sx = IW'(SAT_MAX);
		end else if (rx < RW'(SAT_MIN)) begin
			sx = IW'(SAT_MIN);
		end else begin
			sx = rx[IW-1:0];
		end

		if (ry > RW'(SAT_MAX)) begin
			sy = IW'(SAT_MAX);
		end else if (ry < RW'(SAT_MIN)) begin
			sy = IW'(SAT_MIN);
		end else begin
			sy = ry[IW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= root.vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= root.side;
			c_s1 <= CW'(root.side.c0) + CW'($signed({1'b0, root.root}));

			ex_s2 <= $signed({1'b0, side_s1.eta}) * side_s1.inc_x;
			ey_s2 <= $signed({1'b0, side_s1.eta}) * side_s1.inc_y;
			cx_s2 <= c_s1 * side_s1.norm_x;
			cy_s2 <= c_s1 * side_s1.norm_y;
			tir_s2 <= side_s1.tir;

			out_s3.out_x <= tir_s2 ? '0 : sx;
			out_s3.out_y <= tir_s2 ? '0 : sy;
			out_s3.total_internal <= tir_s2;
		end
	end

	assign out_vld = vld_s3;
	assign out_data = out_s3;

endmodule

// ===== rtl/vector2_refract_top.sv =====
// Channel  Dir  Payload
// req      in   inc_x, inc_y, norm_x, norm_y, eta
// rsp      out  out_x, out_y, total_internal
//
// One item is taken in every cycle while the pipeline is not held; results leave in the order of their transfers.
// The depth is set by the 23-step integer square root, two steps per register stage.
// Reset clears only the valid bits of the pipeline.
// When rsp holds a result that is not taken, the whole pipeline holds and req.ready is low.
module vector2_refract_top (
	input logic clk,
	input logic arst_n,
	v2r_req_if.sink req,
	v2r_rsp_if.source rsp
);
	import v2r_pkg::*;

	logic      en;
	logic      out_vld;
	v2r_mid_t  mid;
	v2r_root_t root;
	v2r_out_t  out_data;

	assign en = !out_vld || rsp.ready;
	assign req.ready = en;

	v2r_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (req.valid),
		.in_data (req.data),
		.mid     (mid)
	);

	v2r_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.mid    (mid),
		.root   (root)
	);

	v2r_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.root     (root),
		.out_vld  (out_vld),
		.out_data (out_data)
	);

	assign rsp.valid = out_vld;
	assign rsp.data = out_data;

endmodule
